FILE: hdl/lop_pkg.sv
// ----------------------------------------------------------------------------
// lop_pkg: shared types, constants and tables for last_digits_of_power
// Holds the field widths, the Barrett constants for each power of ten and
// the command and status words between the controller and the datapath.
// ----------------------------------------------------------------------------
package lop_pkg;

  localparam int BASE_W            = 30;
  localparam int RES_W             = 30;
  localparam int DIGIT_W           = 4;
  localparam int MAX_DIGITS        = 9;
  localparam int EXPONENT_BITS_DEF = 60;
  localparam int MOD_W             = 30;
  localparam int MU_W              = 31;
  localparam int SHIFT_W           = 5;
  localparam int PROD_W            = 2 * MOD_W;
  localparam int RED_CNT_W         = $clog2(BASE_W);

  typedef struct packed {
    logic load;
    logic red_step;
    logic mm_start;
    logic mul_base;
    logic exp_shift;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic exp_msb;
    logic mm_done;
  } sts_t;

  function automatic logic [DIGIT_W-1:0] clamp_digits(input logic [DIGIT_W-1:0] k);
    logic [DIGIT_W-1:0] kc;
    kc = k;
    if (k == '0) begin
      kc = DIGIT_W'(1);
    end else if (k > DIGIT_W'(MAX_DIGITS)) begin
      kc = DIGIT_W'(MAX_DIGITS);
    end
    return kc;
  endfunction

  function automatic logic [MOD_W-1:0] ten_pow(input logic [DIGIT_W-1:0] k);
    logic [MOD_W-1:0] m;
    unique case (k)
      4'd2:    m = 30'd100;
      4'd3:    m = 30'd1000;
      4'd4:    m = 30'd10000;
      4'd5:    m = 30'd100000;
      4'd6:    m = 30'd1000000;
      4'd7:    m = 30'd10000000;
      4'd8:    m = 30'd100000000;
      4'd9:    m = 30'd1000000000;
      default: m = 30'd10;
    endcase
    return m;
  endfunction

  // Bit length n of the modulus, so that 2^(n-1) <= m < 2^n.
  function automatic logic [SHIFT_W-1:0] barrett_n(input logic [DIGIT_W-1:0] k);
    logic [SHIFT_W-1:0] n;
    unique case (k)
      4'd2:    n = 5'd7;
      4'd3:    n = 5'd10;
      4'd4:    n = 5'd14;
      4'd5:    n = 5'd17;
      4'd6:    n = 5'd20;
      4'd7:    n = 5'd24;
      4'd8:    n = 5'd27;
      4'd9:    n = 5'd30;
      default: n = 5'd4;
    endcase
    return n;
  endfunction

  // Reciprocal floor(4^n / m).
  function automatic logic [MU_W-1:0] barrett_mu(input logic [DIGIT_W-1:0] k);
    logic [MU_W-1:0] mu;
    unique case (k)
      4'd2:    mu = 31'd163;
      4'd3:    mu = 31'd1048;
      4'd4:    mu = 31'd26843;
      4'd5:    mu = 31'd171798;
      4'd6:    mu = 31'd1099511;
      4'd7:    mu = 31'd28147497;
      4'd8:    mu = 31'd180143985;
      4'd9:    mu = 31'd1152921504;
      default: mu = 31'd25;
    endcase
    return mu;
  endfunction

endpackage

FILE: hdl/last_digits_of_power.sv
// ----------------------------------------------------------------------------
// last_digits_of_power: last k decimal digits of a^b
// Input word: in_base_value, in_exponent, in_digit_count under in_valid and
// in_stall. Result word: out_power_residue under out_valid and out_stall.
// A word is taken on a clock edge with valid high and stall low.
// The block works on one word at a time. After acceptance it reduces the
// base bit-serially, then scans every exponent bit from the top with a
// four-stage Barrett multiplier: one squaring for every bit and one more
// multiplication by the base for each set bit.
// The result lands in an output register, so a new word is accepted while
// it waits. A stalled receiver holds the finished word there and the next
// word waits in the final state until the register is free.
// Reset empties the output register and returns the controller to idle.
// ----------------------------------------------------------------------------
module last_digits_of_power #(
  parameter int EXPONENT_BITS = lop_pkg::EXPONENT_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [lop_pkg::BASE_W-1:0]  in_base_value,
  input  logic [EXPONENT_BITS-1:0]    in_exponent,
  input  logic [lop_pkg::DIGIT_W-1:0] in_digit_count,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [lop_pkg::RES_W-1:0]   out_power_residue
);
  import lop_pkg::*;

  cmd_t cmd;
  sts_t sts;

  lop_ctrl #(
    .EXPONENT_BITS (EXPONENT_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  lop_dp #(
    .EXPONENT_BITS (EXPONENT_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_base_value     (in_base_value),
    .in_exponent       (in_exponent),
    .in_digit_count    (in_digit_count),
    .out_power_residue (out_power_residue)
  );

endmodule

FILE: hdl/lop_modmul.sv
// ----------------------------------------------------------------------------
// lop_modmul: pipelined Barrett modular multiplier
// Computes x * y mod m for x, y < m in four stages: three multipliers and a final subtract-and-correct stage.
// ----------------------------------------------------------------------------
module lop_modmul (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [lop_pkg::MOD_W-1:0]   x,
  input  logic [lop_pkg::MOD_W-1:0]   y,
  input  logic [lop_pkg::MOD_W-1:0]   modulus,
  input  logic [lop_pkg::MU_W-1:0]    mu,
  input  logic [lop_pkg::SHIFT_W-1:0] n_bits,
  output logic                        done,
  output logic [lop_pkg::MOD_W-1:0]   res
);
  import lop_pkg::*;

  localparam int T_W = 2 * MU_W;
  localparam int D_W = 32;

  logic [3:0]         vld_r, vld_nxt;
  logic [PROD_W-1:0]  p1_r, p1_nxt;
  logic [PROD_W-1:0]  p2_r, p2_nxt;
  logic [PROD_W-1:0]  p3_r, p3_nxt;
  logic [T_W-1:0]     t_r, t_nxt;
  logic [PROD_W-1:0]  qm_r, qm_nxt;
  logic [MOD_W-1:0]   res_r, res_nxt;
  logic [SHIFT_W-1:0] shr_lo, shr_hi;
  logic [PROD_W-1:0]  p_sh;
  logic [T_W-1:0]     t_sh;
  logic [D_W-1:0]     d;
  logic [D_W:0]       d1, d2;

  always_comb begin
    shr_lo  = n_bits - SHIFT_W'(1);
    shr_hi  = n_bits + SHIFT_W'(1);
    p_sh    = p1_r >> shr_lo;
    t_sh    = t_r >> shr_hi;
    vld_nxt = {vld_r[2:0], start};
    p1_nxt  = PROD_W'(x) * PROD_W'(y);
    p2_nxt  = p1_r;
    t_nxt   = T_W'(p_sh[MU_W-1:0]) * T_W'(mu);
    p3_nxt  = p2_r;
    qm_nxt  = PROD_W'(t_sh[MOD_W-1:0]) * PROD_W'(modulus);
    d       = p3_r[D_W-1:0] - qm_r[D_W-1:0];
    d1      = {1'b0, d} - (D_W+1)'(modulus);
    d2      = {1'b0, d} - ((D_W+1)'(modulus) << 1);
    if (!d2[D_W]) begin
      res_nxt = d2[MOD_W-1:0];
    end else if (!d1[D_W]) begin
      res_nxt = d1[MOD_W-1:0];
    end else begin
      res_nxt = d[MOD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p1_r  <= p1_nxt;
    p2_r  <= p2_nxt;
    t_r   <= t_nxt;
    p3_r  <= p3_nxt;
    qm_r  <= qm_nxt;
    res_r <= res_nxt;
  end

  assign done = vld_r[3];
  assign res  = res_r;

`ifndef ASSERT_OFF
  a_done_latency: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> $past(start, 4))
    else $error("Product emerged without a start four cycles earlier.");

  a_res_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (done && $stable(modulus)) |-> (res < modulus))
    else $error("Reduced product is not below the modulus.");
`endif

endmodule

FILE: hdl/lop_dp.sv
// ----------------------------------------------------------------------------
// lop_dp: datapath for last_digits_of_power
// Holds the operands, the serial base reduction, the accumulator, the
// modular multiplier and the result register.
// ----------------------------------------------------------------------------
module lop_dp #(
  parameter int EXPONENT_BITS = lop_pkg::EXPONENT_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lop_pkg::cmd_t               cmd,
  output lop_pkg::sts_t               sts,
  input  logic [lop_pkg::BASE_W-1:0]  in_base_value,
  input  logic [EXPONENT_BITS-1:0]    in_exponent,
  input  logic [lop_pkg::DIGIT_W-1:0] in_digit_count,
  output logic [lop_pkg::RES_W-1:0]   out_power_residue
);
  import lop_pkg::*;

  logic [BASE_W-1:0]        braw_r, braw_nxt;
  logic [MOD_W-1:0]         base_r, base_nxt;
  logic [EXPONENT_BITS-1:0] exp_r, exp_nxt;
  logic [MOD_W-1:0]         mod_r, mod_nxt;
  logic [MU_W-1:0]          mu_r, mu_nxt;
  logic [SHIFT_W-1:0]       nb_r, nb_nxt;
  logic [MOD_W-1:0]         acc_r, acc_nxt;
  logic [RES_W-1:0]         res_out_r, res_out_nxt;
  logic [DIGIT_W-1:0]       kc;
  logic [MOD_W:0]           rem_sh;
  logic                     mm_done;
  logic [MOD_W-1:0]         mm_res;

  always_comb begin
    kc          = clamp_digits(in_digit_count);
    rem_sh      = {base_r, braw_r[BASE_W-1]};
    braw_nxt    = braw_r;
    base_nxt    = base_r;
    exp_nxt     = exp_r;
    mod_nxt     = mod_r;
    mu_nxt      = mu_r;
    nb_nxt      = nb_r;
    acc_nxt     = acc_r;
    res_out_nxt = res_out_r;
    if (cmd.load) begin
      braw_nxt = in_base_value;
      base_nxt = '0;
      exp_nxt  = in_exponent;
      mod_nxt  = ten_pow(kc);
      mu_nxt   = barrett_mu(kc);
      nb_nxt   = barrett_n(kc);
      acc_nxt  = MOD_W'(1);
    end
    if (cmd.red_step) begin
      braw_nxt = braw_r << 1;
      if (rem_sh >= {1'b0, mod_r}) begin
        base_nxt = MOD_W'(rem_sh - {1'b0, mod_r});
      end else begin
        base_nxt = rem_sh[MOD_W-1:0];
      end
    end
    if (cmd.exp_shift) begin
      exp_nxt = exp_r << 1;
    end
    if (mm_done) begin
      acc_nxt = mm_res;
    end
    if (cmd.out_load) begin
      res_out_nxt = RES_W'(acc_r);
    end
  end

  always_ff @(posedge clk) begin
    braw_r    <= braw_nxt;
    base_r    <= base_nxt;
    exp_r     <= exp_nxt;
    mod_r     <= mod_nxt;
    mu_r      <= mu_nxt;
    nb_r      <= nb_nxt;
    acc_r     <= acc_nxt;
    res_out_r <= res_out_nxt;
  end

  lop_modmul u_modmul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.mm_start),
    .x       (acc_r),
    .y       (cmd.mul_base ? base_r : acc_r),
    .modulus (mod_r),
    .mu      (mu_r),
    .n_bits  (nb_r),
    .done    (mm_done),
    .res     (mm_res)
  );

  assign sts.exp_msb       = exp_r[EXPONENT_BITS-1];
  assign sts.mm_done       = mm_done;
  assign out_power_residue = res_out_r;

endmodule

FILE: hdl/lop_ctrl.sv
// ----------------------------------------------------------------------------
// lop_ctrl: controller for last_digits_of_power
// Sequences the base reduction and the square-and-multiply scan over the
// exponent, and owns the handshakes of both channels.
// ----------------------------------------------------------------------------
module lop_ctrl #(
  parameter int EXPONENT_BITS = lop_pkg::EXPONENT_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output lop_pkg::cmd_t cmd,
  input  lop_pkg::sts_t sts
);
  import lop_pkg::*;

  localparam int BC_W = $clog2(EXPONENT_BITS + 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_REDUCE = 3'd1;
  localparam logic [2:0] S_SQ     = 3'd2;
  localparam logic [2:0] S_SQ_W   = 3'd3;
  localparam logic [2:0] S_MUL    = 3'd4;
  localparam logic [2:0] S_MUL_W  = 3'd5;
  localparam logic [2:0] S_FINISH = 3'd6;

  logic [2:0]           state_r, state_nxt;
  logic [RED_CNT_W-1:0] red_cnt_r, red_cnt_nxt;
  logic [BC_W-1:0]      bit_cnt_r, bit_cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    red_cnt_nxt   = red_cnt_r;
    bit_cnt_nxt   = bit_cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load    = 1'b1;
          red_cnt_nxt = RED_CNT_W'(BASE_W - 1);
          state_nxt   = S_REDUCE;
        end
      end
      S_REDUCE: begin
        cmd.red_step = 1'b1;
        if (red_cnt_r == '0) begin
          bit_cnt_nxt = BC_W'(EXPONENT_BITS);
          state_nxt   = S_SQ;
        end else begin
          red_cnt_nxt = red_cnt_r - RED_CNT_W'(1);
        end
      end
      S_SQ: begin
        cmd.mm_start = 1'b1;
        state_nxt    = S_SQ_W;
      end
      S_SQ_W: begin
        if (sts.mm_done) begin
          if (sts.exp_msb) begin
            state_nxt = S_MUL;
          end else begin
            cmd.exp_shift = 1'b1;
            bit_cnt_nxt   = bit_cnt_r - BC_W'(1);
            state_nxt     = (bit_cnt_r == BC_W'(1)) ? S_FINISH : S_SQ;
          end
        end
      end
      S_MUL: begin
        cmd.mm_start = 1'b1;
        cmd.mul_base = 1'b1;
        state_nxt    = S_MUL_W;
      end
      S_MUL_W: begin
        if (sts.mm_done) begin
          cmd.exp_shift = 1'b1;
          bit_cnt_nxt   = bit_cnt_r - BC_W'(1);
          state_nxt     = (bit_cnt_r == BC_W'(1)) ? S_FINISH : S_SQ;
        end
      end
      S_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      red_cnt_r   <= '0;
      bit_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      red_cnt_r   <= red_cnt_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

`ifndef ASSERT_OFF
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !(out_valid_r && out_stall))
    else $error("A pending result word would be overwritten.");

  a_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    sts.mm_done |-> (state_r == S_SQ_W || state_r == S_MUL_W))
    else $error("Multiplier finished while the controller was not waiting.");
`endif

endmodule
